// ===== src/pmfw_pkg.sv =====
package pmfw_pkg;

  localparam int unsigned NumBlocks    = 64;
  localparam int unsigned PagesInBlock = 16;
  localparam int unsigned NumLpn       = 512;
  localparam int unsigned MaxGcRounds  = 64;
  localparam int unsigned NumPages     = NumBlocks * PagesInBlock;

  localparam int unsigned BlkW  = $clog2(NumBlocks);
  localparam int unsigned OffW  = $clog2(PagesInBlock);
  localparam int unsigned LpnW  = $clog2(NumLpn);
  localparam int unsigned PpnW  = $clog2(NumPages);
  localparam int unsigned CntW  = $clog2(NumBlocks + 1);
  localparam int unsigned RndW  = $clog2(MaxGcRounds + 1);

  localparam int unsigned LpnFieldW = 9;
  localparam int unsigned PpnFieldW = 10;
  localparam int unsigned RndFieldW = 7;
  localparam int unsigned MovFieldW = 10;
  localparam int unsigned FreeFieldW = 7;
  localparam int unsigned ThrW = 6;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(2);
  localparam logic [MovFieldW-1:0] MovMax = '1;

  localparam logic [1:0] RegThreshold = 2'd0;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StGcCheck,
    StVicPop,
    StScanRd,
    StScanMap,
    StScanChk,
    StErase,
    StWrite,
    StOut
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load_lpn;
    logic gc_init;
    logic gc_check;
    logic vic_pop;
    logic scan_map;
    logic scan_place;
    logic erase_step;
    logic free_push;
    logic host_place;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic gc_due;
    logic no_closed;
    logic cap_hit;
    logic scan_live;
    logic scan_last;
    logic erase_last;
  } sts_t;

endpackage

// ===== src/pmfw_if.sv =====
interface pmfw_in_if;
  import pmfw_pkg::*;
  logic valid;
  logic ready;
  logic [LpnFieldW-1:0] logical_page;
  modport source (output valid, output logical_page, input ready);
  modport sink (input valid, input logical_page, output ready);
endinterface

interface pmfw_out_if;
  import pmfw_pkg::*;
  logic valid;
  logic ready;
  logic [PpnFieldW-1:0] physical_page;
  logic status;
  logic [RndFieldW-1:0] gc_rounds;
  logic [MovFieldW-1:0] pages_moved;
  logic pages_lost;
  logic stall_warning;
  logic gc_capped;
  logic [FreeFieldW-1:0] free_blocks;
  modport source (output valid, output physical_page, output status, output gc_rounds,
    output pages_moved, output pages_lost, output stall_warning, output gc_capped,
    output free_blocks, input ready);
  modport sink (input valid, input physical_page, input status, input gc_rounds,
    input pages_moved, input pages_lost, input stall_warning, input gc_capped,
    input free_blocks, output ready);
endinterface

// ===== src/page_mapped_flash_write_with_gc.sv =====
// Page-mapped flash write with FIFO garbage collection.
// in_if carries one logical_page per transaction; out_if returns one result
// per transaction: physical page, drop status, GC rounds, pages moved, lost,
// stall, cap flags and the free block count after the write.
// An APB port holds gc_free_threshold at address 0 (reset 2); write it only
// while no transaction is in flight.
// Without GC, an accepted transaction passes through the GC check, write
// and output states before out_if.valid rises. Each GC round adds a check,
// a victim pop, the scan read, map and check states for each page of the
// victim and then an erase of each page. The map and owner tables sit in
// RAMs with registered reads, which is why the scan needs separate states.
// After reset the block clears the owner and map tables and builds the
// free list; in_if.ready stays low meanwhile.
// One item is in flight at a time. A finished result waits in the output
// register while out_if.ready is low; the next item's work may run but the
// new result is held until the register drains.
module page_mapped_flash_write_with_gc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pmfw_in_if.sink                   in_if,
  pmfw_out_if.source                out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pmfw_pkg::*;

  logic [ThrW-1:0] thr_q;
  cmd_t cmd;
  sts_t sts;
  logic out_valid_q;

  logic [PpnFieldW-1:0] ppn;
  logic status, lost, stall, capped;
  logic [RndFieldW-1:0] rounds;
  logic [MovFieldW-1:0] moved;
  logic [FreeFieldW-1:0] freeb;

  assign pready = 1'b1;
  assign prdata = (paddr == RegThreshold) ? 32'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (psel && penable && pwrite && paddr == RegThreshold) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  pmfw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_busy_i(out_valid_q && !out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  pmfw_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .lpn_i(in_if.logical_page), .thr_i(thr_q),
    .ppn_o(ppn), .status_o(status), .rounds_o(rounds), .moved_o(moved),
    .lost_o(lost), .stall_o(stall), .capped_o(capped), .free_o(freeb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_if.physical_page <= ppn;
      out_if.status        <= status;
      out_if.gc_rounds     <= rounds;
      out_if.pages_moved   <= moved;
      out_if.pages_lost    <= lost;
      out_if.stall_warning <= stall;
      out_if.gc_capped     <= capped;
      out_if.free_blocks   <= freeb;
    end
  end

  assign out_if.valid = out_valid_q;
endmodule

// ===== src/pmfw_ram.sv =====
module pmfw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/pmfw_ctrl.sv =====
module pmfw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_busy_i,
  input  pmfw_pkg::sts_t   sts_i,
  output pmfw_pkg::cmd_t   cmd_o
);
  import pmfw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_lpn = 1'b1;
          cmd_o.gc_init  = 1'b1;
          state_d = StGcCheck;
        end
      end
      StGcCheck: begin
        cmd_o.gc_check = 1'b1;
        if (!sts_i.gc_due || sts_i.no_closed || sts_i.cap_hit) begin
          state_d = StWrite;
        end else begin
          state_d = StVicPop;
        end
      end
      StVicPop: begin
        cmd_o.vic_pop = 1'b1;
        state_d = StScanRd;
      end
      StScanRd: begin
        state_d = StScanMap;
      end
      StScanMap: begin
        cmd_o.scan_map = 1'b1;
        state_d = StScanChk;
      end
      StScanChk: begin
        cmd_o.scan_place = sts_i.scan_live;
        state_d = sts_i.scan_last ? StErase : StScanRd;
      end
      StErase: begin
        cmd_o.erase_step = 1'b1;
        if (sts_i.erase_last) begin
          cmd_o.free_push = 1'b1;
          state_d = StGcCheck;
        end
      end
      StWrite: begin
        cmd_o.host_place = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_lpn |-> state_q == StIdle)
    else $error("load outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.vic_pop |=> state_q == StScanRd)
    else $error("pop not followed by scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_busy_i)
    else $error("result overwritten");
endmodule

// ===== src/pmfw_dp.sv =====
module pmfw_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pmfw_pkg::cmd_t                     cmd_i,
  output pmfw_pkg::sts_t                     sts_o,
  input  logic [pmfw_pkg::LpnFieldW-1:0]     lpn_i,
  input  logic [pmfw_pkg::ThrW-1:0]          thr_i,
  output logic [pmfw_pkg::PpnFieldW-1:0]     ppn_o,
  output logic                               status_o,
  output logic [pmfw_pkg::RndFieldW-1:0]     rounds_o,
  output logic [pmfw_pkg::MovFieldW-1:0]     moved_o,
  output logic                               lost_o,
  output logic                               stall_o,
  output logic                               capped_o,
  output logic [pmfw_pkg::FreeFieldW-1:0]    free_o
);
  import pmfw_pkg::*;

  localparam int unsigned MapW = PpnW + 1;
  localparam int unsigned OwnW = LpnW + 1;

  logic [LpnW-1:0] lpn_q;
  logic [BlkW-1:0] free_head_q, closed_head_q, active_q, victim_q;
  logic [CntW-1:0] free_cnt_q, closed_cnt_q;
  logic [OffW-1:0] wofs_q, scan_q;
  logic [OffW:0]   erase_q;
  logic [PpnW:0]   clr_q;
  logic [RndW-1:0] rounds_q;
  logic [MovFieldW-1:0] moved_q;
  logic lost_q, stall_q, capped_q, ok_q;
  logic [PpnW-1:0] ppn_q;
  logic [OwnW-1:0] own_q;
  logic scan_adv_q;

  // free fifo: entry holds block; the clear phase fills it with the identity using this fill count
  logic [BlkW:0] free_wr_q;

  logic map_we, own_we, fr_we, cl_we;
  logic [LpnW-1:0] map_wa, map_ra;
  logic [MapW-1:0] map_wd, map_rd;
  logic [PpnW-1:0] own_wa, own_ra;
  logic [OwnW-1:0] own_wd, own_rd;
  logic [BlkW-1:0] fr_wa, fr_ra, cl_wa, cl_ra;
  logic [BlkW-1:0] fr_wd, fr_rd, cl_wd, cl_rd;

  pmfw_ram #(.Width(MapW), .Depth(NumLpn)) u_map (.clk_i, .we_i(map_we), .waddr_i(map_wa),
    .wdata_i(map_wd), .raddr_i(map_ra), .rdata_o(map_rd));
  pmfw_ram #(.Width(OwnW), .Depth(NumPages)) u_own (.clk_i, .we_i(own_we),
    .waddr_i(own_wa), .wdata_i(own_wd), .raddr_i(own_ra), .rdata_o(own_rd));
  pmfw_ram #(.Width(BlkW), .Depth(NumBlocks)) u_free (.clk_i, .we_i(fr_we), .waddr_i(fr_wa),
    .wdata_i(fr_wd), .raddr_i(fr_ra), .rdata_o(fr_rd));
  pmfw_ram #(.Width(BlkW), .Depth(NumBlocks)) u_closed (.clk_i, .we_i(cl_we),
    .waddr_i(cl_wa), .wdata_i(cl_wd), .raddr_i(cl_ra), .rdata_o(cl_rd));

  logic clearing;
  assign clearing = cmd_i.clr_step;

  // free fifo head read is always at head; registered read data is valid in the cycle after the head changes.
  assign fr_ra = free_head_q;
  logic [BlkW-1:0] fr_head_blk;
  assign fr_head_blk = fr_rd;

  assign cl_ra = closed_head_q;

  // place logic
  logic place_req;
  logic [LpnW-1:0] place_lpn;
  logic place_ok;
  logic [BlkW-1:0] place_blk;
  logic [PpnW-1:0] place_ppn;
  logic place_full;

  assign place_req = cmd_i.host_place | cmd_i.scan_place;
  assign place_lpn = cmd_i.scan_place ? own_q[LpnW-1:0] : lpn_q;
  assign place_ok  = (wofs_q != '0) || (free_cnt_q != '0);
  assign place_blk = (wofs_q == '0) ? fr_head_blk : active_q;
  assign place_ppn = {place_blk, wofs_q};
  assign place_full = (wofs_q == OffW'(PagesInBlock - 1));

  logic [PpnW-1:0] scan_src;
  assign scan_src = {victim_q, scan_q};
  logic [PpnW-1:0] erase_addr;
  assign erase_addr = {victim_q, erase_q[OffW-1:0]};

  always_comb begin
    map_we = 1'b0; map_wa = place_lpn; map_wd = {1'b1, place_ppn};
    own_we = 1'b0; own_wa = place_ppn; own_wd = {1'b1, place_lpn};
    if (clearing) begin
      map_we = !clr_q[PpnW] && (clr_q[PpnW-1:0] < PpnW'(NumLpn));
      map_wa = clr_q[LpnW-1:0]; map_wd = '0;
      own_we = !clr_q[PpnW]; own_wa = clr_q[PpnW-1:0]; own_wd = '0;
    end else if (place_req && place_ok) begin
      map_we = 1'b1; own_we = 1'b1;
    end else if (cmd_i.erase_step) begin
      own_we = 1'b1; own_wa = erase_addr; own_wd = '0;
    end
  end

  assign map_ra = cmd_i.scan_map ? own_rd[LpnW-1:0] : lpn_q;
  assign own_ra = scan_src;

  logic closing;
  assign closing = place_req && place_ok && place_full;

  assign fr_we = clearing ? !free_wr_q[BlkW] : cmd_i.free_push;
  assign fr_wa = clearing ? free_wr_q[BlkW-1:0] : BlkW'(free_head_q + free_cnt_q[BlkW-1:0]);
  assign fr_wd = clearing ? free_wr_q[BlkW-1:0] : victim_q;
  assign cl_we = closing;
  assign cl_wa = BlkW'(closed_head_q + closed_cnt_q[BlkW-1:0]);
  assign cl_wd = place_blk;

  assign sts_o.clr_done  = clr_q[PpnW] && free_wr_q[BlkW];
  assign sts_o.gc_due    = free_cnt_q <= CntW'(thr_i);
  assign sts_o.no_closed = closed_cnt_q == '0;
  assign sts_o.cap_hit   = rounds_q >= RndW'(MaxGcRounds);
  assign sts_o.scan_live = own_q[OwnW-1] && (map_rd == {1'b1, scan_src});
  assign sts_o.scan_last = scan_q == OffW'(PagesInBlock - 1);
  assign sts_o.erase_last = erase_q[OffW-1:0] == OffW'(PagesInBlock - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scan_adv_q <= 1'b0;
    else scan_adv_q <= cmd_i.scan_map;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; free_wr_q <= '0;
      free_head_q <= '0; closed_head_q <= '0;
      free_cnt_q <= CntW'(NumBlocks); closed_cnt_q <= '0;
      wofs_q <= '0; active_q <= '0; victim_q <= '0;
      scan_q <= '0; erase_q <= '0; rounds_q <= '0; moved_q <= '0;
      lost_q <= 1'b0; stall_q <= 1'b0; capped_q <= 1'b0; ok_q <= 1'b0;
      lpn_q <= '0; ppn_q <= '0; own_q <= '0;
    end else begin
      if (clearing) begin
        if (!clr_q[PpnW]) clr_q <= clr_q + 1'b1;
        if (!free_wr_q[BlkW]) free_wr_q <= free_wr_q + 1'b1;
      end
      if (cmd_i.load_lpn) lpn_q <= lpn_i[LpnW-1:0];
      if (cmd_i.gc_init) begin
        rounds_q <= '0; moved_q <= '0; lost_q <= 1'b0;
        stall_q <= 1'b0; capped_q <= 1'b0;
      end
      if (cmd_i.gc_check && sts_o.gc_due) begin
        // record why the gc loop ends while gc is still due
        if (sts_o.no_closed) stall_q <= 1'b1;
        else if (sts_o.cap_hit) capped_q <= 1'b1;
      end
      if (cmd_i.vic_pop) begin
        victim_q <= cl_rd;
        closed_head_q <= closed_head_q + 1'b1;
        closed_cnt_q <= closed_cnt_q - 1'b1;
        scan_q <= '0;
        erase_q <= '0;
      end
      if (cmd_i.scan_map) own_q <= own_rd;
      if (place_req) begin
        if (place_ok) begin
          active_q <= place_blk;
          ppn_q <= place_ppn;
          wofs_q <= place_full ? '0 : wofs_q + 1'b1;
          if (cmd_i.scan_place && moved_q != MovMax) moved_q <= moved_q + 1'b1;
        end else if (cmd_i.scan_place) begin
          lost_q <= 1'b1;
        end
        if (cmd_i.host_place) ok_q <= place_ok;
      end
      if (closing) begin
        free_head_q <= free_head_q + 1'b1;
        closed_cnt_q <= closed_cnt_q + 1'b1;
      end
      if (scan_adv_q) scan_q <= scan_q + 1'b1;
      if (cmd_i.erase_step) begin
        erase_q <= erase_q + 1'b1;
        if (sts_o.erase_last) rounds_q <= rounds_q + 1'b1;
      end
      if (cmd_i.free_push || closing) begin
        free_cnt_q <= free_cnt_q - CntW'(closing) + CntW'(cmd_i.free_push);
      end
    end
  end

  assign ppn_o    = ok_q ? PpnFieldW'(ppn_q) : '0;
  assign status_o = !ok_q;
  assign rounds_o = RndFieldW'(rounds_q);
  assign moved_o  = moved_q;
  assign lost_o   = lost_q;
  assign stall_o  = stall_q;
  assign capped_o = capped_q;
  assign free_o   = FreeFieldW'(free_cnt_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vic_pop |-> closed_cnt_q != '0)
    else $error("pop from empty closed fifo");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CntW'(NumBlocks) && closed_cnt_q <= CntW'(NumBlocks))
    else $error("fifo count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_push |-> free_cnt_q < CntW'(NumBlocks))
    else $error("push into full free fifo");
endmodule
